[rtl/cls_pkg.sv]
package cls_pkg;

	localparam int POS_W      = 16;
	localparam int TOK_W      = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int LEN_MAX    = (1 << TOK_W) - 1;
	localparam int KW_COUNT   = 4;
	localparam int KW_MAXLEN  = 5;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [TOK_W-1:0] len_t;
	typedef logic [4:0]       kind_t;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_IDENT = 4'd1,
		M_DEC   = 4'd2,
		M_ZERO  = 4'd3,
		M_HEX   = 4'd4,
		M_LT    = 4'd5,
		M_GT    = 4'd6,
		M_BANG  = 4'd7,
		M_HALT  = 4'd8
	} mode_t;

	localparam kind_t T_IDENT = 5'd0;
	localparam kind_t T_NUM   = 5'd1;
	localparam kind_t T_ASSN  = 5'd2;
	localparam kind_t T_SEMI  = 5'd3;
	localparam kind_t T_LPAR  = 5'd4;
	localparam kind_t T_RPAR  = 5'd5;
	localparam kind_t T_LBRC  = 5'd6;
	localparam kind_t T_RBRC  = 5'd7;
	localparam kind_t T_LT    = 5'd8;
	localparam kind_t T_GT    = 5'd9;
	localparam kind_t T_SHL   = 5'd10;
	localparam kind_t T_SHR   = 5'd11;
	localparam kind_t T_PLUS  = 5'd12;
	localparam kind_t T_MINUS = 5'd13;
	localparam kind_t T_STAR  = 5'd14;
	localparam kind_t T_SLASH = 5'd15;
	localparam kind_t T_AMP   = 5'd16;
	localparam kind_t T_BAR   = 5'd17;
	localparam kind_t T_CARET = 5'd18;
	localparam kind_t T_NOT   = 5'd19;
	localparam kind_t T_KW0   = 5'd20;
	localparam kind_t T_END   = 5'd24;

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd3};
	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00},
		'{"w", "h", "i", "l", "e"},
		'{"f", "o", "r", 8'h00, 8'h00}
	};

	typedef struct packed {
		kind_t kind;
		len_t  start;
		len_t  length;
		logic  last;
	} tok_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_xdigit(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic id_start(logic [7:0] c);
		return is_alpha(c) || c == "_";
	endfunction

	function automatic logic id_char(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	function automatic kind_t single_kind(logic [7:0] c);
		kind_t k;
		case (c)
			"=": k = T_ASSN;
			";": k = T_SEMI;
			"(": k = T_LPAR;
			")": k = T_RPAR;
			"{": k = T_LBRC;
			"}": k = T_RBRC;
			"+": k = T_PLUS;
			"-": k = T_MINUS;
			"*": k = T_STAR;
			"/": k = T_SLASH;
			"&": k = T_AMP;
			"|": k = T_BAR;
			"^": k = T_CARET;
			"~": k = T_NOT;
			default: k = T_IDENT;
		endcase
		return k;
	endfunction

	// Keeps the keywords whose text still matches at character index idx.
	function automatic logic [KW_COUNT-1:0] update_hits(logic [KW_COUNT-1:0] hits,
			logic [7:0] c, pos_t idx);
		logic [KW_COUNT-1:0] keep;
		keep = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (hits[k] && idx < POS_W'(KW_LEN[k])) begin
				if (KW_TEXT[k][idx[2:0]] == c)
					keep[k] = 1'b1;
			end
		end
		return keep;
	endfunction

	function automatic len_t sat_len(logic [POS_W:0] v);
		return (v > LEN_MAX) ? len_t'(LEN_MAX) : len_t'(v);
	endfunction

	function automatic tok_t mk_tok(kind_t kind, pos_t start, len_t length);
		tok_t t;
		t.kind   = kind;
		t.start  = len_t'(start);
		t.length = length;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage

[rtl/cls_tok_fifo.sv]
module cls_tok_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  cls_pkg::tok_t tok0,
	input  cls_pkg::tok_t tok1,
	output logic          room2,
	output logic          out_valid,
	input  logic          out_ready,
	output cls_pkg::tok_t head
);
	import cls_pkg::*;

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] wptr1;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign room2     = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign head      = mem_q[rptr_q];
	assign wptr1     = wptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wptr_q] <= tok0;
		if (push_n == 2'd2)
			mem_q[wptr1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(push_n);
			if (pop)
				rptr_q <= rptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q + CNT_W'(push_n) <= CNT_W'(FIFO_DEPTH))
		else $error("token queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> !pop)
		else $error("token queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue count out of range");
`endif

endmodule

[rtl/c_subset_char_lexer_top.sv]
// Streaming lexer for a small C subset. Each transfer on the input carries one character
// (op = 0) or an end-of-input mark (op = 1); tokens come out as type, start offset and length,
// with last set on the final token caused by that input item. The block takes one item per
// cycle unless stalled: the item is registered, mode logic classifies it against the pending
// token, and its zero, one or two tokens enter a four-entry token queue. The first token of
// an item passes the input register and the queue storage before it is valid on the output.
// The queue drains one token per cycle while out_ready is high, so the sustained rate is one
// item per cycle as long as items average no more than one token each; an item waits in the
// input register, whatever number of tokens it gives, while the queue holds more than two
// tokens. After an end token the block ignores all further items until reset.
module c_subset_char_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_type,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last
);
	import cls_pkg::*;

	logic                valid_s1;
	logic                op_s1;
	logic [7:0]          ch_s1;

	mode_t               mode_q, mode_n;
	pos_t                pos_q, pos_n;
	pos_t                tb_q, tb_n;
	logic [KW_COUNT-1:0] hits_q, hits_n;

	logic                room2;
	logic                proc;
	logic [1:0]          push_n;
	tok_t                tok0, tok1, head;

	pos_t                plen;
	len_t                plen16, plen_p1;
	logic                go_idle, flush;
	logic                f_v, s_v;
	tok_t                f_tok, s_tok;
	kind_t               id_kind;

	assign proc     = valid_s1 && room2;
	assign in_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= op;
			ch_s1 <= ch;
		end
	end

	assign plen    = pos_q - tb_q;
	assign plen16  = sat_len({1'b0, plen});
	assign plen_p1 = sat_len({1'b0, plen} + (POS_W + 1)'(1));

	always_comb begin
		id_kind = T_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (hits_q[k] && plen == POS_W'(KW_LEN[k]))
				id_kind = kind_t'(T_KW0 + k);
		end
	end

	always_comb begin
		mode_n  = mode_q;
		tb_n    = tb_q;
		hits_n  = hits_q;
		go_idle = 1'b0;
		flush   = 1'b0;
		f_v     = 1'b0;
		f_tok   = mk_tok(T_IDENT, tb_q, plen16);
		s_v     = 1'b0;
		s_tok   = mk_tok(T_END, pos_q, '0);
		if (mode_q != M_HALT) begin
			if (op_s1) begin
				s_v    = 1'b1;
				mode_n = M_HALT;
				// A pending bang reports the end at its own offset and is not flushed.
				if (mode_q == M_BANG)
					s_tok = mk_tok(T_END, tb_q, '0);
				else
					flush = 1'b1;
			end else begin
				case (mode_q)
					M_IDLE: go_idle = 1'b1;
					M_IDENT: begin
						if (id_char(ch_s1))
							hits_n = update_hits(hits_q, ch_s1, plen);
						else
							go_idle = 1'b1;
					end
					M_DEC: go_idle = !is_digit(ch_s1);
					M_ZERO: begin
						if (ch_s1 == "x" || ch_s1 == "X")
							mode_n = M_HEX;
						else if (is_digit(ch_s1))
							mode_n = M_DEC;
						else
							go_idle = 1'b1;
					end
					M_HEX: go_idle = !is_xdigit(ch_s1);
					M_LT: begin
						if (ch_s1 == "<") begin
							s_v    = 1'b1;
							s_tok  = mk_tok(T_SHL, tb_q, plen_p1);
							mode_n = M_IDLE;
						end else begin
							go_idle = 1'b1;
						end
					end
					M_GT: begin
						if (ch_s1 == ">") begin
							s_v    = 1'b1;
							s_tok  = mk_tok(T_SHR, tb_q, plen_p1);
							mode_n = M_IDLE;
						end else begin
							go_idle = 1'b1;
						end
					end
					M_BANG: begin
						s_v = 1'b1;
						if (ch_s1 == "=") begin
							s_tok  = mk_tok(T_NOT, tb_q, plen_p1);
							mode_n = M_IDLE;
						end else begin
							s_tok  = mk_tok(T_END, tb_q, '0);
							mode_n = M_HALT;
						end
					end
					default: ;
				endcase
				flush = go_idle;
			end

			if (flush) begin
				case (mode_q)
					M_IDENT: begin
						f_v   = 1'b1;
						f_tok = mk_tok(id_kind, tb_q, plen16);
					end
					M_DEC, M_ZERO, M_HEX: begin
						f_v   = 1'b1;
						f_tok = mk_tok(T_NUM, tb_q, plen16);
					end
					M_LT: begin
						f_v   = 1'b1;
						f_tok = mk_tok(T_LT, tb_q, len_t'(1));
					end
					M_GT: begin
						f_v   = 1'b1;
						f_tok = mk_tok(T_GT, tb_q, len_t'(1));
					end
					default: ;
				endcase
			end

			// A non-space char that ends a token, or comes in idle, is lexed afresh.
			if (go_idle) begin
				mode_n = M_IDLE;
				if (!is_space(ch_s1)) begin
					tb_n = pos_q;
					if (ch_s1 == "<") begin
						mode_n = M_LT;
					end else if (ch_s1 == ">") begin
						mode_n = M_GT;
					end else if (ch_s1 == "!") begin
						mode_n = M_BANG;
					end else if (single_kind(ch_s1) != T_IDENT) begin
						s_v   = 1'b1;
						s_tok = mk_tok(single_kind(ch_s1), pos_q, len_t'(1));
					end else if (is_digit(ch_s1)) begin
						mode_n = (ch_s1 == "0") ? M_ZERO : M_DEC;
					end else if (id_start(ch_s1)) begin
						mode_n = M_IDENT;
						hits_n = update_hits({KW_COUNT{1'b1}}, ch_s1, '0);
					end else begin
						s_v    = 1'b1;
						s_tok  = mk_tok(T_END, pos_q, '0);
						mode_n = M_HALT;
					end
				end
			end
		end
	end

	always_comb begin
		pos_n = pos_q;
		if (mode_q != M_HALT && !op_s1 && pos_q != {POS_W{1'b1}})
			pos_n = pos_q + POS_W'(1);
	end

	always_comb begin
		push_n = proc ? (2'(f_v) + 2'(s_v)) : 2'd0;
		tok0   = f_v ? f_tok : s_tok;
		tok0.last = !(f_v && s_v);
		tok1   = s_tok;
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			tb_q   <= '0;
			hits_q <= '0;
		end else if (proc) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			tb_q   <= tb_n;
			hits_q <= hits_n;
		end
	end

	cls_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.tok0      (tok0),
		.tok1      (tok1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign token_type   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.length;
	assign last         = head.last;

`ifndef ASSERT_OFF
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_HALT |-> push_n == 2'd0)
		else $error("tokens given after the end token");
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == M_HALT |=> mode_q == M_HALT)
		else $error("lexer left the halted mode");
	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		proc && s_v && s_tok.kind == T_END |=> mode_q == M_HALT)
		else $error("end token given without halting");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(op_s1) && $stable(ch_s1))
		else $error("stalled input item lost");
`endif

endmodule
